// ===== rtl/tms_pkg.sv =====
// Shared types and constants for the transform mode sequencer.
// Holds payload structs, mode and rod codes, register indexes and reset values.
// No dependencies.
package tms_pkg;

   // Field widths
   localparam int POS_BITS   = 12;
   localparam int TIME_BITS  = 32;
   localparam int ROD_T_BITS = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Servo settle window, in position counts
   localparam logic [POS_BITS-1:0] CLOSE_ENOUGH = POS_BITS'(70);

   // Switch positions
   localparam logic [1:0] SW_UP   = 2'd1;
   localparam logic [1:0] SW_DOWN = 2'd2;

   typedef enum logic [2:0] {
      MODE_INIT       = 3'd0,
      MODE_STOP       = 3'd1,
      MODE_FLY        = 3'd2,
      MODE_GROUND     = 3'd3,
      MODE_G2F_ROD    = 3'd4,
      MODE_G2F_SERVO  = 3'd5,
      MODE_F2G_SERVO  = 3'd6,
      MODE_F2G_ROD    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ROD_OFF     = 2'd0,
      ROD_RETRACT = 2'd1,
      ROD_EXTEND  = 2'd2
   } rod_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRONT_FLY    = 3'd0,
      CSR_REAR_FLY     = 3'd1,
      CSR_FRONT_GROUND = 3'd2,
      CSR_REAR_GROUND  = 3'd3,
      CSR_EXTEND_TIME  = 3'd4,
      CSR_RETRACT_TIME = 3'd5,
      CSR_MOVE_SPEED   = 3'd6,
      CSR_SERVO_ACCEL  = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic [POS_BITS-1:0]   RST_TARGET       = POS_BITS'(2048);
   localparam logic [ROD_T_BITS-1:0] RST_ROD_TIME     = ROD_T_BITS'(3000);
   localparam logic [15:0]           RST_MOVE_SPEED   = 16'd1000;
   localparam logic [7:0]            RST_SERVO_ACCEL  = 8'd50;

   typedef struct packed {
      logic [TIME_BITS-1:0] tick_time;
      logic [1:0]           enable_switch;
      logic [1:0]           shape_switch;
      logic [POS_BITS-1:0]  front_servo_pos;
      logic [POS_BITS-1:0]  rear_servo_pos;
   } req_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic                torque_cmd_valid;
      logic                torque_on;
      logic                rod_cmd_valid;
      logic [1:0]          rod_cmd;
      logic                pos_cmd_valid;
      logic [POS_BITS-1:0] front_target_out;
      logic [POS_BITS-1:0] rear_target_out;
   } rsp_type;

   // Configuration values seen by the sequencing logic
   typedef struct packed {
      logic [POS_BITS-1:0]   front_fly_target;
      logic [POS_BITS-1:0]   rear_fly_target;
      logic [POS_BITS-1:0]   front_ground_target;
      logic [POS_BITS-1:0]   rear_ground_target;
      logic [ROD_T_BITS-1:0] extend_time;
      logic [ROD_T_BITS-1:0] retract_time;
      logic [15:0]           move_speed;
      logic [7:0]            servo_accel;
   } cfg_type;

endpackage

// ===== rtl/tms_csr.sv =====
// Configuration register file for the transform mode sequencer.
// Depends on tms_pkg for register indexes, widths and reset values.
module tms_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [tms_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tms_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output tms_pkg::cfg_type                     cfg
);

   tms_pkg::cfg_type cfg_ff;
   tms_pkg::cfg_type cfg_in;

   // Update the addressed register, truncated to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (tms_pkg::csr_index_type'(csr_index))
            tms_pkg::CSR_FRONT_FLY:
               cfg_in.front_fly_target = csr_data[tms_pkg::POS_BITS-1:0];
            tms_pkg::CSR_REAR_FLY:
               cfg_in.rear_fly_target = csr_data[tms_pkg::POS_BITS-1:0];
            tms_pkg::CSR_FRONT_GROUND:
               cfg_in.front_ground_target = csr_data[tms_pkg::POS_BITS-1:0];
            tms_pkg::CSR_REAR_GROUND:
               cfg_in.rear_ground_target = csr_data[tms_pkg::POS_BITS-1:0];
            tms_pkg::CSR_EXTEND_TIME:
               cfg_in.extend_time = csr_data[tms_pkg::ROD_T_BITS-1:0];
            tms_pkg::CSR_RETRACT_TIME:
               cfg_in.retract_time = csr_data[tms_pkg::ROD_T_BITS-1:0];
            tms_pkg::CSR_MOVE_SPEED:
               cfg_in.move_speed = csr_data[15:0];
            tms_pkg::CSR_SERVO_ACCEL:
               cfg_in.servo_accel = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_fly_target    <= tms_pkg::RST_TARGET;
         cfg_ff.rear_fly_target     <= tms_pkg::RST_TARGET;
         cfg_ff.front_ground_target <= tms_pkg::RST_TARGET;
         cfg_ff.rear_ground_target  <= tms_pkg::RST_TARGET;
         cfg_ff.extend_time         <= tms_pkg::RST_ROD_TIME;
         cfg_ff.retract_time        <= tms_pkg::RST_ROD_TIME;
         cfg_ff.move_speed          <= tms_pkg::RST_MOVE_SPEED;
         cfg_ff.servo_accel         <= tms_pkg::RST_SERVO_ACCEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tms_core.sv =====
// Mode state and per-tick update logic for the transform mode sequencer.
// Depends on tms_pkg for the mode codes, payload and configuration structs.
module tms_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tms_pkg::req_type  item,
   input  tms_pkg::cfg_type  cfg,
   output tms_pkg::rsp_type  result
);

   tms_pkg::mode_type              mode_ff, mode_in;
   tms_pkg::mode_type              saved_ff, saved_in;
   logic [tms_pkg::TIME_BITS-1:0]  start_ff, start_in;

   logic [tms_pkg::TIME_BITS-1:0]  now;
   logic [tms_pkg::TIME_BITS-1:0]  extend_end;
   logic [tms_pkg::TIME_BITS-1:0]  retract_end;
   logic                           extend_done;
   logic                           retract_done;
   logic                           fly_settled;
   logic                           ground_settled;
   logic                           entered;

   // Absolute difference below the settle window
   function automatic logic near_target(input logic [tms_pkg::POS_BITS-1:0] pos,
                                        input logic [tms_pkg::POS_BITS-1:0] target);
      logic [tms_pkg::POS_BITS-1:0] diff;
      diff = (pos >= target) ? (pos - target) : (target - pos);
      return diff < tms_pkg::CLOSE_ENOUGH;
   endfunction

   // Rod phase end times wrap with the time counter
   assign now          = item.tick_time[tms_pkg::TIME_BITS-1:0];
   assign extend_end   = start_ff + tms_pkg::TIME_BITS'(cfg.extend_time);
   assign retract_end  = start_ff + tms_pkg::TIME_BITS'(cfg.retract_time);
   assign extend_done  = now > extend_end;
   assign retract_done = now > retract_end;

   assign fly_settled    = near_target(item.front_servo_pos, cfg.front_fly_target)
                         & near_target(item.rear_servo_pos, cfg.rear_fly_target);
   assign ground_settled = near_target(item.front_servo_pos, cfg.front_ground_target)
                         & near_target(item.rear_servo_pos, cfg.rear_ground_target);

   // Next mode; disable takes priority over everything
   always_comb begin
      mode_in  = mode_ff;
      saved_in = saved_ff;
      start_in = start_ff;
      priority if (item.enable_switch == tms_pkg::SW_DOWN) begin
         if (mode_ff != tms_pkg::MODE_STOP) begin
            saved_in = mode_ff;
         end
         mode_in = tms_pkg::MODE_STOP;
      end else begin
         unique case (mode_ff)
            tms_pkg::MODE_STOP: begin
               mode_in = saved_ff;
            end
            tms_pkg::MODE_INIT: begin
               mode_in  = tms_pkg::MODE_F2G_ROD;
               start_in = now;
            end
            tms_pkg::MODE_FLY: begin
               if (item.shape_switch == tms_pkg::SW_DOWN) begin
                  mode_in  = tms_pkg::MODE_F2G_ROD;
                  start_in = now;
               end
            end
            tms_pkg::MODE_GROUND: begin
               if (item.shape_switch == tms_pkg::SW_UP) begin
                  mode_in  = tms_pkg::MODE_G2F_ROD;
                  start_in = now;
               end
            end
            tms_pkg::MODE_G2F_ROD: begin
               if (extend_done) begin
                  mode_in = tms_pkg::MODE_G2F_SERVO;
               end
            end
            tms_pkg::MODE_G2F_SERVO: begin
               if (fly_settled) begin
                  mode_in = tms_pkg::MODE_FLY;
               end
            end
            tms_pkg::MODE_F2G_SERVO: begin
               if (ground_settled) begin
                  mode_in = tms_pkg::MODE_GROUND;
               end
            end
            tms_pkg::MODE_F2G_ROD: begin
               if (retract_done) begin
                  mode_in = tms_pkg::MODE_F2G_SERVO;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   assign entered = (mode_in != mode_ff);

   // Commands for the new mode; transitions issue them on entry only
   always_comb begin
      result                  = '0;
      result.mode             = mode_in;
      unique case (mode_in)
         tms_pkg::MODE_INIT, tms_pkg::MODE_STOP: begin
            result.torque_cmd_valid = 1'b1;
            result.rod_cmd_valid    = 1'b1;
            result.rod_cmd          = tms_pkg::ROD_OFF;
         end
         tms_pkg::MODE_FLY: begin
            result.torque_cmd_valid = 1'b1;
            result.torque_on        = 1'b1;
            result.rod_cmd_valid    = 1'b1;
            result.rod_cmd          = tms_pkg::ROD_EXTEND;
         end
         tms_pkg::MODE_GROUND: begin
            result.torque_cmd_valid = 1'b1;
            result.torque_on        = 1'b1;
            result.rod_cmd_valid    = 1'b1;
            result.rod_cmd          = tms_pkg::ROD_RETRACT;
         end
         tms_pkg::MODE_G2F_ROD: begin
            if (entered) begin
               result.torque_cmd_valid = 1'b1;
               result.rod_cmd_valid    = 1'b1;
               result.rod_cmd          = tms_pkg::ROD_EXTEND;
            end
         end
         tms_pkg::MODE_G2F_SERVO: begin
            if (entered) begin
               result.torque_cmd_valid = 1'b1;
               result.torque_on        = 1'b1;
               result.rod_cmd_valid    = 1'b1;
               result.rod_cmd          = tms_pkg::ROD_EXTEND;
               result.pos_cmd_valid    = 1'b1;
               result.front_target_out = cfg.front_fly_target;
               result.rear_target_out  = cfg.rear_fly_target;
            end
         end
         tms_pkg::MODE_F2G_SERVO: begin
            if (entered) begin
               result.torque_cmd_valid = 1'b1;
               result.torque_on        = 1'b1;
               result.rod_cmd_valid    = 1'b1;
               result.rod_cmd          = tms_pkg::ROD_RETRACT;
               result.pos_cmd_valid    = 1'b1;
               result.front_target_out = cfg.front_ground_target;
               result.rear_target_out  = cfg.rear_ground_target;
            end
         end
         tms_pkg::MODE_F2G_ROD: begin
            if (entered) begin
               result.torque_cmd_valid = 1'b1;
               result.rod_cmd_valid    = 1'b1;
               result.rod_cmd          = tms_pkg::ROD_RETRACT;
            end
         end
         default: result.mode = mode_in;
      endcase
   end

   // Commit the state when the tick moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tms_pkg::MODE_INIT;
         saved_ff <= tms_pkg::MODE_INIT;
         start_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         saved_ff <= saved_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== rtl/transform_mode_sequencer.sv =====
// Top level of the transform mode sequencer: input and result registers.
// Depends on tms_pkg, tms_csr and tms_core.
//
// Takes one control tick per clock cycle while req_ready is high and returns
// exactly one result beat per tick, in order. A tick is captured in an input
// register at its accepting edge, the mode update and command selection run as
// one pass of compare-and-select logic, and the result register loads the
// outcome once it is free or draining, and offers it as the result beat.
// While a finished result waits on rsp_ready, the input register takes one more
// tick and then req_ready drops until the result leaves; the throughput is one
// tick per cycle whenever the result side takes beats. Configuration writes are
// taken at any time (csr_ready is always high) and should be issued only while
// no tick is in flight.
module transform_mode_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tms_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tms_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tms_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic              in_valid_ff, in_valid_in;
   tms_pkg::req_type  in_data_ff, in_data_in;
   logic              out_valid_ff, out_valid_in;
   tms_pkg::rsp_type  out_data_ff, out_data_in;
   logic              advance;
   tms_pkg::cfg_type  cfg;
   tms_pkg::rsp_type  result;

   assign csr_ready = 1'b1;

   tms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tms_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move a tick forward when the result register is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload holds need no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== bench/tms_bench_pkg.sv =====
// Scoreboard for the transform mode sequencer bench: mode predictor and result check.
// Depends on tms_pkg for payload structs, mode, rod and register codes.
package tms_bench_pkg;
   import tms_pkg::*;

   class mode_scoreboard;
      // register copy, as the block should hold it
      logic [POS_BITS-1:0]   front_fly, rear_fly, front_ground, rear_ground;
      logic [ROD_T_BITS-1:0] extend_time, retract_time;
      logic [15:0]           move_speed;
      logic [7:0]            servo_accel;
      // sequencing state
      mode_type              mode_now, mode_prev, mode_saved;
      logic [TIME_BITS-1:0]  move_start;
      // commands predicted for ticks whose result beat has not come yet
      rsp_type               expected_cmds[$];
      int unsigned           errors, beats_ok, disables;
      int unsigned           mode_visits[8];

      function new();
         front_fly    = RST_TARGET;
         rear_fly     = RST_TARGET;
         front_ground = RST_TARGET;
         rear_ground  = RST_TARGET;
         extend_time  = RST_ROD_TIME;
         retract_time = RST_ROD_TIME;
         move_speed   = RST_MOVE_SPEED;
         servo_accel  = RST_SERVO_ACCEL;
         mode_now     = MODE_INIT;
         mode_prev    = MODE_INIT;
         mode_saved   = MODE_INIT;
         move_start   = '0;
         errors       = 0;
         beats_ok     = 0;
         disables     = 0;
         foreach (mode_visits[i]) mode_visits[i] = 0;
      endfunction

      // Mirror one register write, trimmed to the register width
      function void set_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_FRONT_FLY:    front_fly    = value[POS_BITS-1:0];
            CSR_REAR_FLY:     rear_fly     = value[POS_BITS-1:0];
            CSR_FRONT_GROUND: front_ground = value[POS_BITS-1:0];
            CSR_REAR_GROUND:  rear_ground  = value[POS_BITS-1:0];
            CSR_EXTEND_TIME:  extend_time  = value[ROD_T_BITS-1:0];
            CSR_RETRACT_TIME: retract_time = value[ROD_T_BITS-1:0];
            CSR_MOVE_SPEED:   move_speed   = value[15:0];
            CSR_SERVO_ACCEL:  servo_accel  = value[7:0];
            default: ;
         endcase
      endfunction

      function bit settled(logic [POS_BITS-1:0] pos, logic [POS_BITS-1:0] target);
         logic [POS_BITS-1:0] gap;
         gap = (pos >= target) ? pos - target : target - pos;
         return gap < CLOSE_ENOUGH;
      endfunction

      // End time wraps with the time counter; compare is plain unsigned
      function bit rods_done(logic [TIME_BITS-1:0] now, logic [ROD_T_BITS-1:0] need);
         logic [TIME_BITS-1:0] finish_at;
         finish_at = move_start + TIME_BITS'(need);
         return now > finish_at;
      endfunction

      // Advance the mode for one accepted tick and queue the commands it gives
      function void note_tick(req_type t);
         mode_type m;
         rsp_type  cmd;
         bit       entered;
         m = mode_now;
         if (t.enable_switch == SW_DOWN) begin
            if (m != MODE_STOP) mode_saved = m;
            m = MODE_STOP;
            disables++;
         end else begin
            case (mode_now)
               MODE_STOP: m = mode_saved;
               MODE_INIT: begin
                  m = MODE_F2G_ROD;
                  move_start = t.tick_time;
               end
               MODE_FLY: if (t.shape_switch == SW_DOWN) begin
                  m = MODE_F2G_ROD;
                  move_start = t.tick_time;
               end
               MODE_GROUND: if (t.shape_switch == SW_UP) begin
                  m = MODE_G2F_ROD;
                  move_start = t.tick_time;
               end
               MODE_G2F_ROD: if (rods_done(t.tick_time, extend_time)) m = MODE_G2F_SERVO;
               MODE_G2F_SERVO:
                  if (settled(t.front_servo_pos, front_fly) &&
                      settled(t.rear_servo_pos, rear_fly)) m = MODE_FLY;
               MODE_F2G_SERVO:
                  if (settled(t.front_servo_pos, front_ground) &&
                      settled(t.rear_servo_pos, rear_ground)) m = MODE_GROUND;
               default: if (rods_done(t.tick_time, retract_time)) m = MODE_F2G_SERVO;
            endcase
         end
         mode_prev = mode_now;
         mode_now  = m;
         entered   = (mode_prev != mode_now);

         // Steady modes command every tick, transitions only on entry
         cmd      = '0;
         cmd.mode = mode_now;
         case (mode_now)
            MODE_INIT, MODE_STOP: begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_OFF;
            end
            MODE_FLY: begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.torque_on        = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_EXTEND;
            end
            MODE_GROUND: begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.torque_on        = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_RETRACT;
            end
            MODE_G2F_ROD: if (entered) begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_EXTEND;
            end
            MODE_G2F_SERVO: if (entered) begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.torque_on        = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_EXTEND;
               cmd.pos_cmd_valid    = 1'b1;
               cmd.front_target_out = front_fly;
               cmd.rear_target_out  = rear_fly;
            end
            MODE_F2G_SERVO: if (entered) begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.torque_on        = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_RETRACT;
               cmd.pos_cmd_valid    = 1'b1;
               cmd.front_target_out = front_ground;
               cmd.rear_target_out  = rear_ground;
            end
            default: if (entered) begin
               cmd.torque_cmd_valid = 1'b1;
               cmd.rod_cmd_valid    = 1'b1;
               cmd.rod_cmd          = ROD_RETRACT;
            end
         endcase
         mode_visits[mode_now]++;
         expected_cmds.push_back(cmd);
      endfunction

      function bit same_field(longint unsigned stamp, string field,
                              int unsigned want, int unsigned got);
         if (want == got) return 1'b1;
         errors++;
         if (errors <= 30)
            $display("%0d ns: %s mismatch, expected %0d, got %0d", stamp, field, want, got);
         return 1'b0;
      endfunction

      // Compare one result beat against the oldest prediction
      function void check_beat(rsp_type got, longint unsigned stamp);
         rsp_type want;
         bit      ok;
         if (expected_cmds.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0d ns: result beat with nothing pending, expected none, got %h",
                        stamp, got);
            return;
         end
         want = expected_cmds.pop_front();
         ok = same_field(stamp, "mode", want.mode, got.mode);
         ok &= same_field(stamp, "torque_cmd_valid", want.torque_cmd_valid,
                          got.torque_cmd_valid);
         ok &= same_field(stamp, "torque_on", want.torque_on, got.torque_on);
         ok &= same_field(stamp, "rod_cmd_valid", want.rod_cmd_valid, got.rod_cmd_valid);
         ok &= same_field(stamp, "rod_cmd", want.rod_cmd, got.rod_cmd);
         ok &= same_field(stamp, "pos_cmd_valid", want.pos_cmd_valid, got.pos_cmd_valid);
         ok &= same_field(stamp, "front_target_out", want.front_target_out,
                          got.front_target_out);
         ok &= same_field(stamp, "rear_target_out", want.rear_target_out,
                          got.rear_target_out);
         if (ok) beats_ok++;
      endfunction
   endclass

endpackage

// ===== bench/transform_mode_sequencer_tb.sv =====
// Self-checking bench for transform_mode_sequencer: directed and random control ticks.
// Depends on tms_pkg and tms_bench_pkg (mode_scoreboard); drives all three channels.
module transform_mode_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tms_pkg::*;
   import tms_bench_pkg::*;

   // Switch codes the package leaves unnamed
   localparam logic [1:0] SW_MID   = 2'd0;
   localparam logic [1:0] SW_SPARE = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   mode_scoreboard sb = new();

   int unsigned          send_idle_pct = 0;
   int unsigned          rsp_stall_pct = 0;
   int unsigned          hold_cycles   = 0;
   logic [TIME_BITS-1:0] tick_now      = '0;
   logic [15:0]          cfg_vals [8];

   transform_mode_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Receiver: hold off on request, else stall at the phase rate
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watch every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_tick(req_data);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data, $time);
         if (csr_valid && csr_ready) sb.set_reg(csr_index_type'(csr_index), csr_data);
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned n;
      n = 0;
      while (n < 200 && $urandom_range(99) < send_idle_pct) n++;
      return n;
   endfunction

   // Offer one tick after a random idle gap; return at its accepting edge
   task automatic send_tick(input req_type t);
      int unsigned gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait out every pending result, then let the pipeline settle
   task automatic wait_drain();
      while (sb.expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all registers from cfg_vals, one beat each
   task automatic load_config();
      csr_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= cfg_vals[idx];
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [POS_BITS-1:0] pick_target();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return POS_BITS'($urandom());
      endcase
   endfunction

   // Random targets with junk in the unused upper bits, short rod times
   function automatic void random_config();
      cfg_vals[CSR_FRONT_FLY]    = {4'($urandom()), pick_target()};
      cfg_vals[CSR_REAR_FLY]     = {4'($urandom()), pick_target()};
      cfg_vals[CSR_FRONT_GROUND] = {4'($urandom()), pick_target()};
      cfg_vals[CSR_REAR_GROUND]  = {4'($urandom()), pick_target()};
      cfg_vals[CSR_EXTEND_TIME]  = 16'($urandom_range(30));
      cfg_vals[CSR_RETRACT_TIME] = 16'($urandom_range(30));
      cfg_vals[CSR_MOVE_SPEED]   = 16'($urandom());
      cfg_vals[CSR_SERVO_ACCEL]  = 16'($urandom());
   endfunction

   function automatic logic [POS_BITS-1:0] near_pos(logic [POS_BITS-1:0] target);
      int p;
      p = int'(target) + int'($urandom_range(140)) - 70;
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return POS_BITS'(p);
   endfunction

   function automatic req_type tick(logic [TIME_BITS-1:0] now, logic [1:0] en,
                                    logic [1:0] shape, logic [POS_BITS-1:0] front,
                                    logic [POS_BITS-1:0] rear);
      req_type t;
      t.tick_time       = now;
      t.enable_switch   = en;
      t.shape_switch    = shape;
      t.front_servo_pos = front;
      t.rear_servo_pos  = rear;
      return t;
   endfunction

   // Mostly a steadily advancing clock with positions near a target set
   function automatic req_type make_tick();
      int unsigned         roll;
      logic [1:0]          en;
      logic [POS_BITS-1:0] front, rear;
      roll = $urandom_range(99);
      if (roll < 2) tick_now = $urandom();
      else if (roll < 4) tick_now = 32'hFFFF_FFFF - $urandom_range(40);
      else tick_now = tick_now + $urandom_range(12);

      roll = $urandom_range(99);
      if (roll < 6) en = SW_DOWN;
      else if (roll < 60) en = SW_MID;
      else if (roll < 90) en = SW_UP;
      else en = SW_SPARE;

      roll = $urandom_range(99);
      if (roll < 40) begin
         front = near_pos(sb.front_fly);
         rear  = near_pos(sb.rear_fly);
      end else if (roll < 80) begin
         front = near_pos(sb.front_ground);
         rear  = near_pos(sb.rear_ground);
      end else begin
         front = POS_BITS'($urandom());
         rear  = POS_BITS'($urandom());
      end
      return tick(tick_now, en, 2'($urandom_range(3)), front, rear);
   endfunction

   task automatic run_phase(input int unsigned n, input int unsigned idle_pct,
                            input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_tick(make_tick());
      stop_sending();
      wait_drain();
   endtask

   // Walk the whole sequence by hand: window edges, disable and restore,
   // zero and maximum rod times, and an early rod end at the time wrap
   task automatic directed_ticks();
      send_tick(tick(32'd0,     SW_MID,   SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd5,     SW_UP,    SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd65535, SW_MID,   SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd65536, SW_SPARE, SW_MID,   12'd0,    12'd4095));
      send_tick(tick(32'd65537, SW_MID,   SW_MID,   12'd4025, 12'd0));
      send_tick(tick(32'd65538, SW_MID,   SW_MID,   12'd4026, 12'd69));
      send_tick(tick(32'd65539, SW_DOWN,  SW_UP,    12'd0,    12'd0));
      send_tick(tick(32'd65540, SW_DOWN,  SW_DOWN,  12'd0,    12'd0));
      send_tick(tick(32'd65541, SW_MID,   SW_UP,    12'd0,    12'd0));
      send_tick(tick(32'd65542, SW_UP,    SW_UP,    12'd0,    12'd0));
      send_tick(tick(32'd65542, SW_MID,   SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd65543, SW_MID,   SW_MID,   12'd4095, 12'd0));
      send_tick(tick(32'd65544, SW_DOWN,  SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd65545, SW_SPARE, SW_MID,   12'd0,    12'd0));
      send_tick(tick(32'd65546, SW_MID,   SW_MID,   12'd70,   12'd4095));
      send_tick(tick(32'd65547, SW_MID,   SW_MID,   12'd69,   12'd4026));
      send_tick(tick(32'd65548, SW_MID,   SW_SPARE, 12'd0,    12'd0));
      send_tick(tick(32'hFFFF_FFF0, SW_MID, SW_DOWN, 12'd0,   12'd0));
      send_tick(tick(32'hFFFF_FFF1, SW_UP,  SW_MID,  12'd0,   12'd0));
      send_tick(tick(32'hFFFF_FFF2, SW_MID, SW_MID,  12'd4095, 12'd0));
      send_tick(tick(32'hFFFF_FFFF, SW_DOWN, SW_SPARE, 12'd4095, 12'd4095));
      send_tick(tick(32'd0,     SW_MID,   SW_MID,   12'd0,    12'd0));
      stop_sending();
      wait_drain();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Extreme settings for the hand-written walk
      cfg_vals[CSR_FRONT_FLY]    = 16'h0000;
      cfg_vals[CSR_REAR_FLY]     = 16'hFFFF;
      cfg_vals[CSR_FRONT_GROUND] = 16'h0FFF;
      cfg_vals[CSR_REAR_GROUND]  = 16'hF000;
      cfg_vals[CSR_EXTEND_TIME]  = 16'h0000;
      cfg_vals[CSR_RETRACT_TIME] = 16'hFFFF;
      cfg_vals[CSR_MOVE_SPEED]   = 16'hFFFF;
      cfg_vals[CSR_SERVO_ACCEL]  = 16'hFFFF;
      load_config();
      directed_ticks();

      // Random phases: no idling, slow sender, slow receiver, light both
      tick_now = '0;
      random_config();
      load_config();
      run_phase(345, 0, 0);
      random_config();
      load_config();
      run_phase(345, 86, 0);
      random_config();
      load_config();
      run_phase(345, 0, 86);
      random_config();
      load_config();
      run_phase(345, 13, 13);

      // Back-pressure: receiver holds off while ticks keep coming
      random_config();
      cfg_vals[CSR_MOVE_SPEED]  = 16'h0000;
      cfg_vals[CSR_SERVO_ACCEL] = 16'h0000;
      load_config();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles   = 80;
      repeat (50) send_tick(make_tick());
      stop_sending();
      wait_drain();

      repeat (10) @(posedge clock);
      $display("Checked %0d result beats over six register settings and four idle mixes,",
               sb.beats_ok);
      $display("with %0d disable ticks; ticks per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.disables, sb.mode_visits[0], sb.mode_visits[1], sb.mode_visits[2],
               sb.mode_visits[3], sb.mode_visits[4], sb.mode_visits[5],
               sb.mode_visits[6], sb.mode_visits[7]);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Give up on a stuck block
   initial begin
      #5_000_000;
      $display("Timed out with %0d results still pending", sb.expected_cmds.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
